// ===== sv/ubf_pkg.sv =====
// Shared types, constants and helper functions for the unique-base finder.
// No dependencies; every other file of the block imports this package.
package ubf_pkg;

   localparam int MAX_SEQUENCES = 4;
   localparam int IN_LANES      = 4;
   localparam int LANES         = (MAX_SEQUENCES < IN_LANES) ? MAX_SEQUENCES : IN_LANES;

   localparam int BASE_W     = 8;
   localparam int COORD_W    = 32;
   localparam int INDEX_W    = 2;
   localparam int ACTIVE_W   = 3;
   localparam int REVERSE_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Offset is column count minus gap count, a signed 33-bit value.
   localparam int OFFSET_W = COORD_W + 1;
   // Contig arithmetic needs two more bits for the start add and the sign.
   localparam int SUM_W    = COORD_W + 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START3  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE = 3'd5;

   localparam logic [BASE_W-1:0] GAP_CHAR = 8'h2D;

   localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET  = 3'd2;
   localparam logic [COORD_W-1:0]   START_RESET   = 32'd1;
   localparam logic [REVERSE_W-1:0] REVERSE_RESET = 4'd0;
   localparam logic [COORD_W-1:0]   COLUMN_RESET  = 32'd1;

   typedef struct packed {
      logic [LANES-1:0]              mask;
      logic [LANES-1:0][COORD_W-1:0] coord;
      logic [COORD_W-1:0]            master;
   } column_type;

   typedef struct packed {
      logic       push;
      column_type col;
   } push_type;

   // Gap or upper-case ambiguity code: such a column yields no results.
   function automatic logic is_ambiguous(input logic [BASE_W-1:0] b);
      logic hit;
      case (b)
         "Y", "R", "W", "S", "K", "M", "D", "V", "H", "B", "N", "-": hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Clamp a signed contig sum into the unsigned 32-bit coordinate range.
   function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v[SUM_W-1]) begin
         r = '0;
      end else if (v[SUM_W-2:COORD_W] != '0) begin
         r = '1;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/ubf_lane.sv =====
// One sequence lane: gap counter, ungapped offset register and contig coordinate.
// Depends on ubf_pkg.
module ubf_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           active,
   input  logic [ubf_pkg::BASE_W-1:0]     base,
   input  logic [ubf_pkg::COORD_W-1:0]    column_count,
   input  logic [ubf_pkg::COORD_W-1:0]    start,
   input  logic                           reverse,
   output logic [ubf_pkg::OFFSET_W-1:0]   offset,
   output logic [ubf_pkg::COORD_W-1:0]    coord
);
   import ubf_pkg::*;

   logic [COORD_W-1:0]  gap_ff;
   logic [COORD_W-1:0]  gap_in;
   logic [OFFSET_W-1:0] offset_ff;
   logic [OFFSET_W-1:0] offset_in;
   logic [SUM_W-1:0]    start_ext;
   logic [SUM_W-1:0]    offset_ext;
   logic [SUM_W-1:0]    sum;

   always_comb begin
      gap_in = gap_ff;
      if (accept && active && (base == GAP_CHAR)) begin
         gap_in = gap_ff + COORD_W'(1);
      end
   end

   // The offset uses the gap count before this column; a column that
   // produces results has no gap, so the count is the same either way.
   always_comb begin
      offset_in = offset_ff;
      if (accept) begin
         offset_in = {1'b0, column_count} - {1'b0, gap_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else begin
         gap_ff <= gap_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
   end

   always_comb begin
      start_ext  = {{(SUM_W-COORD_W){1'b0}}, start};
      offset_ext = {{(SUM_W-OFFSET_W){offset_ff[OFFSET_W-1]}}, offset_ff};
      if (reverse) begin
         sum = start_ext - offset_ext + SUM_W'(1);
      end else begin
         sum = start_ext + offset_ext - SUM_W'(1);
      end
   end

   assign offset = offset_ff;
   assign coord  = sat_coord(sum);

endmodule

// ===== sv/ubf_merge.sv =====
// Column queue and result serializer: emits one result per set lane bit.
// Depends on ubf_pkg.
module ubf_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  ubf_pkg::push_type               wr,
   output logic [ubf_pkg::FIFO_CNT_W-1:0]  count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ubf_pkg::INDEX_W-1:0]     rsp_seq_index,
   output logic [ubf_pkg::COORD_W-1:0]     rsp_contig_coord,
   output logic [ubf_pkg::COORD_W-1:0]     rsp_master_coord,
   output logic                            rsp_last_of_column
);
   import ubf_pkg::*;

   column_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic [FIFO_CNT_W-1:0]   count_in;
   logic [LANES-1:0]        sent_ff;
   logic [LANES-1:0]        sent_in;
   column_type              head;
   logic [LANES-1:0]        remain;
   logic [LANES-1:0]        pick;
   logic [INDEX_W-1:0]      idx;
   logic                    last;
   logic                    transfer;
   logic                    pop;

   assign head   = mem_ff[rd_ptr_ff];
   assign remain = head.mask & ~sent_ff;

   always_comb begin
      idx = '0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (remain[i]) begin
            idx = INDEX_W'(i);
         end
      end
   end

   assign pick     = LANES'(1) << idx;
   assign last     = (remain & ~pick) == '0;
   assign transfer = rsp_valid && rsp_ready;
   assign pop      = transfer && last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      sent_in   = sent_ff;
      if (wr.push) begin
         wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(1);
         sent_in   = '0;
      end else if (transfer) begin
         sent_in = sent_ff | pick;
      end
      if (wr.push && !pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (pop && !wr.push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sent_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sent_ff   <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.push) begin
         mem_ff[wr_ptr_ff] <= wr.col;
      end
   end

   assign count              = count_ff;
   assign rsp_valid          = count_ff != '0;
   assign rsp_seq_index      = idx;
   assign rsp_contig_coord   = head.coord[idx];
   assign rsp_master_coord   = head.master;
   assign rsp_last_of_column = last;

endmodule

// ===== sv/alignment_unique_base_finder.sv =====
// Top level of the alignment unique-base finder: registers, lanes and merge.
// Depends on ubf_pkg, ubf_lane and ubf_merge.
//
// One alignment column is taken per clock cycle when the result queue has
// room. A column passes one register stage in the per-sequence lanes, where
// its uniqueness mask and each lane's ungapped offset are captured, and is
// then written with its saturated contig coordinates into a four-entry column
// queue; its first result is presented once the column has been written there.
// A column with k unique bases gives k results, one per cycle while rsp_ready
// is high, in ascending sequence order, and columns with no unique base
// take no queue entry. The input stalls only when the queue, counting the
// column in flight, is full, so sparse bursts of results are absorbed
// without backpressure. Configuration writes take effect at once and must
// be made while no column is in flight.
module alignment_unique_base_finder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ubf_pkg::BASE_W-1:0]        req_base_seq0,
   input  logic [ubf_pkg::BASE_W-1:0]        req_base_seq1,
   input  logic [ubf_pkg::BASE_W-1:0]        req_base_seq2,
   input  logic [ubf_pkg::BASE_W-1:0]        req_base_seq3,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ubf_pkg::INDEX_W-1:0]       rsp_seq_index,
   output logic [ubf_pkg::COORD_W-1:0]       rsp_contig_coord,
   output logic [ubf_pkg::COORD_W-1:0]       rsp_master_coord,
   output logic                              rsp_last_of_column,
   input  logic                              csr_write_en,
   input  logic [ubf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ubf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ubf_pkg::*;

   logic [ACTIVE_W-1:0]               active_ff;
   logic [IN_LANES-1:0][COORD_W-1:0]  start_ff;
   logic [REVERSE_W-1:0]              reverse_ff;
   logic [COORD_W-1:0]                column_ff;
   logic [COORD_W-1:0]                column_in;
   logic                              s1_valid_ff;
   logic [LANES-1:0]                  s1_mask_ff;
   logic [LANES-1:0]                  s1_mask_in;

   logic [IN_LANES-1:0][BASE_W-1:0]   bases;
   logic [ACTIVE_W-1:0]               lane_count;
   logic [LANES-1:0]                  lane_active;
   logic                              clean;
   logic                              accept;
   logic                              s1_push;
   logic [OFFSET_W-1:0]               lane_offset [LANES];
   logic [LANES-1:0][COORD_W-1:0]     lane_coord;
   logic [FIFO_CNT_W-1:0]             queue_count;
   push_type                          wr;

   assign bases  = {req_base_seq3, req_base_seq2, req_base_seq1, req_base_seq0};
   assign accept = req_valid && req_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= ACTIVE_RESET;
         start_ff   <= {IN_LANES{START_RESET}};
         reverse_ff <= REVERSE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ACTIVE:  active_ff   <= csr_wdata[ACTIVE_W-1:0];
            CSR_START0:  start_ff[0] <= csr_wdata[COORD_W-1:0];
            CSR_START1:  start_ff[1] <= csr_wdata[COORD_W-1:0];
            CSR_START2:  start_ff[2] <= csr_wdata[COORD_W-1:0];
            CSR_START3:  start_ff[3] <= csr_wdata[COORD_W-1:0];
            CSR_REVERSE: reverse_ff  <= csr_wdata[REVERSE_W-1:0];
            default: ;
         endcase
      end
   end

   // A lane count of zero behaves as one; counts above the lane limit clamp.
   always_comb begin
      lane_count = active_ff;
      if (active_ff == '0) begin
         lane_count = ACTIVE_W'(1);
      end else if (active_ff > ACTIVE_W'(LANES)) begin
         lane_count = ACTIVE_W'(LANES);
      end
      for (int i = 0; i < LANES; i++) begin
         lane_active[i] = ACTIVE_W'(i) < lane_count;
      end
   end

   always_comb begin
      clean = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         if (lane_active[i] && is_ambiguous(bases[i])) begin
            clean = 1'b0;
         end
      end
      for (int i = 0; i < LANES; i++) begin
         s1_mask_in[i] = clean && lane_active[i];
         for (int j = 0; j < LANES; j++) begin
            if ((j != i) && lane_active[j] && (bases[j] == bases[i])) begin
               s1_mask_in[i] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      column_in = column_ff;
      if (accept) begin
         column_in = column_ff + COORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= COLUMN_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         column_ff   <= column_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mask_ff <= s1_mask_in;
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      ubf_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .accept       (accept),
         .active       (lane_active[g]),
         .base         (bases[g]),
         .column_count (column_ff),
         .start        (start_ff[g]),
         .reverse      (reverse_ff[g]),
         .offset       (lane_offset[g]),
         .coord        (lane_coord[g])
      );
   end

   assign s1_push = s1_valid_ff && (s1_mask_ff != '0);

   always_comb begin
      wr.push       = s1_push;
      wr.col.mask   = s1_mask_ff;
      wr.col.coord  = lane_coord;
      wr.col.master = lane_offset[0][OFFSET_W-1] ? '0 : lane_offset[0][COORD_W-1:0];
   end

   // Room must remain for the column still in the lane stage.
   assign req_ready = ({1'b0, queue_count} + (FIFO_CNT_W + 1)'(s1_push))
                      < (FIFO_CNT_W + 1)'(FIFO_DEPTH);

   ubf_merge u_merge (
      .clock              (clock),
      .reset              (reset),
      .wr                 (wr),
      .count              (queue_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_seq_index      (rsp_seq_index),
      .rsp_contig_coord   (rsp_contig_coord),
      .rsp_master_coord   (rsp_master_coord),
      .rsp_last_of_column (rsp_last_of_column)
   );

endmodule

// ===== sv/ubf_checker.sv =====
// Port-level checks for the unique-base finder, bound to the top level.
// Depends on ubf_pkg and alignment_unique_base_finder.
module ubf_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [ubf_pkg::INDEX_W-1:0]       rsp_seq_index,
   input  logic [ubf_pkg::COORD_W-1:0]       rsp_contig_coord,
   input  logic [ubf_pkg::COORD_W-1:0]       rsp_master_coord,
   input  logic                              rsp_last_of_column
);
   import ubf_pkg::*;

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seq_index)
         && $stable(rsp_contig_coord) && $stable(rsp_master_coord)
         && $stable(rsp_last_of_column))
      else $error("result changed while stalled");

   // Right after reset the queue is empty and the input takes a transfer.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && req_ready)
      else $error("block not idle right after reset");

   // The highest lane can only be the last result of its column.
   a_top_lane_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_seq_index == INDEX_W'(LANES - 1)) |-> rsp_last_of_column)
      else $error("highest lane not marked last of column");

   // Within a column, results follow at once in ascending lane order and
   // share one master coordinate.
   a_column_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_column |=> rsp_valid
         && (rsp_seq_index > $past(rsp_seq_index)) && $stable(rsp_master_coord))
      else $error("column results out of order");

endmodule

bind alignment_unique_base_finder ubf_checker u_ubf_checker (.*);

// ===== tb/tb_alignment_unique_base_finder.sv =====
// Self-checking testbench for the alignment unique-base finder: random and directed columns,
// a scoreboard fed by an in-bench column predictor, and randomized valid/ready throttling.
// Depends only on ubf_pkg and the alignment_unique_base_finder RTL.
`timescale 1ns / 1ps

module tb_alignment_unique_base_finder;
   import ubf_pkg::*;

   typedef logic [IN_LANES-1:0][BASE_W-1:0] col_bytes_type;

   typedef struct {
      logic [INDEX_W-1:0] seq_index;
      logic [COORD_W-1:0] contig_coord;
      logic [COORD_W-1:0] master_coord;
      logic               last_of_column;
   } unique_hit_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BASE_W-1:0]     req_base_seq0 = '0;
   logic [BASE_W-1:0]     req_base_seq1 = '0;
   logic [BASE_W-1:0]     req_base_seq2 = '0;
   logic [BASE_W-1:0]     req_base_seq3 = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [INDEX_W-1:0]    rsp_seq_index;
   logic [COORD_W-1:0]    rsp_contig_coord;
   logic [COORD_W-1:0]    rsp_master_coord;
   logic                  rsp_last_of_column;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Register shadow and column state of the predictor.
   logic [ACTIVE_W-1:0]  lanes_cfg = ACTIVE_RESET;
   logic [COORD_W-1:0]   start_cfg [IN_LANES] = '{START_RESET, START_RESET, START_RESET,
                                                  START_RESET};
   logic [REVERSE_W-1:0] rev_cfg = REVERSE_RESET;
   logic [COORD_W-1:0]   col_cnt = COLUMN_RESET;
   logic [COORD_W-1:0]   gap_cnt [IN_LANES] = '{0, 0, 0, 0};

   logic [BASE_W-1:0] ambig_codes [12] = '{"Y", "R", "W", "S", "K", "M", "D", "V", "H", "B",
                                           "N", "-"};
   logic [BASE_W-1:0] nucleotides [4] = '{"A", "C", "G", "T"};

   col_bytes_type  columns_waiting [$];
   unique_hit_type hits_expected [$];
   col_bytes_type  on_bus = '0;
   bit             offering = 1'b0;
   bit             steady = 1'b0;
   int             stall_orders = 0;
   int             stall_served = 0;
   int             hold_left = 0;
   int             mismatches = 0;

   alignment_unique_base_finder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_base_seq0      (req_base_seq0),
      .req_base_seq1      (req_base_seq1),
      .req_base_seq2      (req_base_seq2),
      .req_base_seq3      (req_base_seq3),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_seq_index      (rsp_seq_index),
      .rsp_contig_coord   (rsp_contig_coord),
      .rsp_master_coord   (rsp_master_coord),
      .rsp_last_of_column (rsp_last_of_column),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit is_unclean(input logic [BASE_W-1:0] b);
      for (int k = 0; k < 12; k++) begin
         if (b == ambig_codes[k]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
      if (v < 0) return '0;
      if (v > longint'(32'hFFFF_FFFF)) return '1;
      return v[COORD_W-1:0];
   endfunction

   // Updates the gap and column counters and queues the hits one column produces.
   task automatic predict_column(input col_bytes_type c);
      int             n;
      bit             clean;
      bit             uniq;
      longint         master;
      longint         ungapped;
      longint         coord;
      unique_hit_type hit;
      unique_hit_type found [$];
      n = lanes_cfg;
      if (n < 1) n = 1;
      if (n > LANES) n = LANES;
      clean = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (c[i] == GAP_CHAR) gap_cnt[i] = gap_cnt[i] + 1;
         if (is_unclean(c[i])) clean = 1'b0;
      end
      if (clean) begin
         master = longint'(col_cnt) - longint'(gap_cnt[0]);
         for (int i = 0; i < n; i++) begin
            uniq = 1'b1;
            for (int j = 0; j < n; j++) begin
               if (j != i && c[j] == c[i]) uniq = 1'b0;
            end
            if (uniq) begin
               ungapped = longint'(col_cnt) - longint'(gap_cnt[i]);
               if (rev_cfg[i]) coord = longint'(start_cfg[i]) - ungapped + 1;
               else coord = longint'(start_cfg[i]) + ungapped - 1;
               hit.seq_index = i[INDEX_W-1:0];
               hit.contig_coord = clamp_coord(coord);
               hit.master_coord = clamp_coord(master);
               hit.last_of_column = 1'b0;
               found.push_back(hit);
            end
         end
         if (found.size() != 0) found[found.size()-1].last_of_column = 1'b1;
         foreach (found[k]) hits_expected.push_back(found[k]);
      end
      col_cnt = col_cnt + 1;
   endtask

   // Column source: offers the next pending column once the previous one has transferred.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_column(on_bus);
            offering = 1'b0;
         end
         if (!req_valid || req_ready) begin
            if (columns_waiting.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
               on_bus = columns_waiting.pop_front();
               offering = 1'b1;
               req_valid <= 1'b1;
               req_base_seq0 <= on_bus[0];
               req_base_seq1 <= on_bus[1];
               req_base_seq2 <= on_bus[2];
               req_base_seq3 <= on_bus[3];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result sink: checks every transfer against the oldest predicted hit.
   always @(posedge clock) begin
      unique_hit_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (hits_expected.size() == 0) begin
               $display("%0t: unexpected result seq %0d contig %0d master %0d last %0b",
                        $time, rsp_seq_index, rsp_contig_coord, rsp_master_coord,
                        rsp_last_of_column);
               mismatches++;
            end else begin
               want = hits_expected.pop_front();
               if (rsp_seq_index !== want.seq_index) begin
                  $display("%0t: seq_index expected %0d, actual %0d", $time,
                           want.seq_index, rsp_seq_index);
                  mismatches++;
               end
               if (rsp_contig_coord !== want.contig_coord) begin
                  $display("%0t: contig_coord expected %0d, actual %0d", $time,
                           want.contig_coord, rsp_contig_coord);
                  mismatches++;
               end
               if (rsp_master_coord !== want.master_coord) begin
                  $display("%0t: master_coord expected %0d, actual %0d", $time,
                           want.master_coord, rsp_master_coord);
                  mismatches++;
               end
               if (rsp_last_of_column !== want.last_of_column) begin
                  $display("%0t: last_of_column expected %0b, actual %0b", $time,
                           want.last_of_column, rsp_last_of_column);
                  mismatches++;
               end
            end
         end
         // A long hold-off lets the column queue fill so that the input stalls.
         if (stall_served != stall_orders) begin
            stall_served = stall_orders;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 7);
         end
      end
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ACTIVE:  lanes_cfg = data[ACTIVE_W-1:0];
         CSR_START0:  start_cfg[0] = data;
         CSR_START1:  start_cfg[1] = data;
         CSR_START2:  start_cfg[2] = data;
         CSR_START3:  start_cfg[3] = data;
         CSR_REVERSE: rev_cfg = data[REVERSE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setup(input logic [ACTIVE_W-1:0] lanes, input logic [COORD_W-1:0] s0,
                              input logic [COORD_W-1:0] s1, input logic [COORD_W-1:0] s2,
                              input logic [COORD_W-1:0] s3, input logic [REVERSE_W-1:0] rev);
      write_register(CSR_ACTIVE, CSR_DATA_W'(lanes));
      write_register(CSR_START0, s0);
      write_register(CSR_START1, s1);
      write_register(CSR_START2, s2);
      write_register(CSR_START3, s3);
      write_register(CSR_REVERSE, CSR_DATA_W'(rev));
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Columns that produce no hit may still be in the pipeline, hence the grace cycles.
   task automatic wait_drained();
      do @(posedge clock);
      while (columns_waiting.size() != 0 || offering || hits_expected.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [BASE_W-1:0] ordinary_byte();
      logic [BASE_W-1:0] b;
      do b = BASE_W'($urandom_range(255));
      while (is_unclean(b));
      return b;
   endfunction

   // Mostly clean columns drawn from a few symbols so that unique and repeated bases
   // mix; the rest carry an ambiguity code or are fully random bytes.
   function automatic col_bytes_type random_column();
      col_bytes_type     c;
      logic [BASE_W-1:0] pool [4];
      int                mode;
      int                kinds;
      mode = $urandom_range(99);
      kinds = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) begin
         pool[i] = $urandom_range(1) ? nucleotides[$urandom_range(3)] : ordinary_byte();
      end
      for (int i = 0; i < IN_LANES; i++) c[i] = pool[$urandom_range(kinds - 1)];
      if (mode >= 95) begin
         for (int i = 0; i < IN_LANES; i++) c[i] = BASE_W'($urandom_range(255));
      end else if (mode >= 80) begin
         c[$urandom_range(IN_LANES - 1)] = ambig_codes[$urandom_range(11)];
      end
      return c;
   endfunction

   task automatic add_column(input logic [BASE_W-1:0] b0, input logic [BASE_W-1:0] b1,
                             input logic [BASE_W-1:0] b2, input logic [BASE_W-1:0] b3);
      columns_waiting.push_back({b3, b2, b1, b0});
   endtask

   task automatic add_random(input int count);
      repeat (count) columns_waiting.push_back(random_column());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: two lanes, plus strand, start at one.
      add_column("A", "C", "A", "A");
      add_column("G", "G", "T", "T");
      add_column("-", "A", "C", "C");
      add_column("T", "N", "G", "C");
      add_column("a", "y", "N", "-");
      add_column(8'h00, 8'hFF, 8'h00, 8'hFF);
      add_column("C", "G", "-", "N");
      add_column(8'hFF, 8'h00, 8'hFF, 8'h00);
      wait_drained();

      // Four lanes with saturating starts on both strands, then a long result stall.
      apply_setup(3'd4, 32'd100, 32'd0, 32'hFFFF_FFFF, 32'd5, 4'b1010);
      add_column("A", "C", "G", "T");
      add_column("A", "A", "C", "G");
      add_column("A", "A", "A", "C");
      add_column("A", "A", "A", "A");
      add_column("A", "C", "A", "C");
      add_column("A", "C", "G", "M");
      add_column("-", "A", "C", "G");
      add_column("t", "g", "c", "a");
      stall_orders <= stall_orders + 1;
      add_random(30);
      wait_drained();

      // Single lane without any idling: every clean column is unique.
      steady <= 1'b1;
      apply_setup(3'd1, 32'd7, 32'd1, 32'd1, 32'd1, 4'b0001);
      add_column("A", "A", "A", "A");
      add_column("-", "C", "C", "C");
      add_column("N", "G", "G", "G");
      add_random(20);
      wait_drained();
      steady <= 1'b0;

      // Lane count zero behaves as one.
      apply_setup(3'd0, 32'hFFFF_FFF0, 32'd1, 32'd1, 32'd1, 4'b0000);
      add_random(15);
      wait_drained();

      // Lane count above the limit behaves as four, all lanes on the minus strand.
      apply_setup(3'd7, $urandom, $urandom, $urandom, $urandom, 4'b1111);
      add_random(25);
      wait_drained();

      apply_setup(3'd3, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1, 4'b0101);
      add_random(20);
      wait_drained();
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
